[hdl/rqts_pkg.sv]
// Shared types and constants for the ready queue with timed sleep.
// Holds the request and result payload structs and the controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package rqts_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int TASK_ID_BITS_DEF = 8;
    localparam int TASK_FIELD_BITS  = 8;
    localparam int TIME_BITS        = 32;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_PICK   = 2'd1,
        REQ_KILL   = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req_code;

    typedef enum logic [2:0] {
        ST_PUSHED  = 3'd0,
        ST_DROPPED = 3'd1,
        ST_READY   = 3'd2,
        ST_WAITED  = 3'd3,
        ST_MAIN    = 3'd4,
        ST_NONE    = 3'd5,
        ST_KILLED  = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [TASK_FIELD_BITS-1:0] task_id;
        logic                       sleep_request;
        logic [TIME_BITS-1:0]       sleep_ms;
        logic [TIME_BITS-1:0]       now_ms;
    } t_req_item;

    typedef struct packed {
        logic [2:0]                 status;
        logic [TASK_FIELD_BITS-1:0] chosen_task;
        logic [TIME_BITS-1:0]       wait_ms;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_in;
        logic    push;
        logic    rd_en;
        logic    wr_shift;
        logic    scan_clear;
        logic    scan_eval;
        logic    load_ready;
        logic    load_best;
        logic    kill_main;
        logic    dec_count;
        logic    emit;
        t_status emit_status;
        logic    emit_held;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       full;
        logic       empty;
        logic       main_alive;
        logic       ready_hit;
    } t_dp_stat;

endpackage

[hdl/rqts_dpath.sv]
// Datapath of the ready queue: entry memory, queue count, best-sleeper tracking
// and the result register. Depends on rqts_pkg.
`timescale 1ns / 1ps

module rqts_dpath
    import rqts_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_req_item                      i_req,
    input  t_dp_cmd                        i_cmd,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_rd_addr,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_wr_addr,
    output t_dp_stat                       o_stat,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_best_pos,
    output t_result                        o_result,
    output logic                           o_strobe
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [TASK_ID_BITS-1:0] r_mem_task [QUEUE_DEPTH];
    logic                    r_mem_sleep [QUEUE_DEPTH];
    logic [TIME_BITS-1:0]    r_mem_wake [QUEUE_DEPTH];

    t_req_item               r_in;
    logic [CW-1:0]           r_count;
    logic                    r_main_alive;
    logic [TASK_ID_BITS-1:0] r_rd_task;
    logic                    r_rd_sleep;
    logic [TIME_BITS-1:0]    r_rd_wake;
    logic [AW-1:0]           r_rd_addr_q;
    logic                    r_have_best;
    logic [TIME_BITS-1:0]    r_best_wait;
    logic [AW-1:0]           r_best_pos;
    logic [TASK_ID_BITS-1:0] r_best_task;
    t_status                 r_res_status;
    logic [TASK_ID_BITS-1:0] r_res_task;
    logic [TIME_BITS-1:0]    r_res_wait;
    t_result                 r_out;
    logic                    r_strobe;

    t_status                 n_res_status;
    logic [TASK_ID_BITS-1:0] n_res_task;
    logic [TIME_BITS-1:0]    n_res_wait;

    logic [TIME_BITS:0]      wake_sum;
    logic [TIME_BITS-1:0]    push_wake;
    logic [TIME_BITS-1:0]    remaining;
    logic                    ready_hit;
    logic                    take_best;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [TASK_ID_BITS-1:0] wr_task;
    logic                    wr_sleep;
    logic [TIME_BITS-1:0]    wr_wake;

    // Wake time saturates at the top of the 32-bit range.
    assign wake_sum  = {1'b0, r_in.now_ms} + {1'b0, r_in.sleep_ms};
    assign push_wake = !r_in.sleep_request ? r_in.now_ms :
                       (wake_sum[TIME_BITS] ? '1 : wake_sum[TIME_BITS-1:0]);

    assign ready_hit = !r_rd_sleep || (r_in.now_ms >= r_rd_wake);
    assign remaining = r_rd_wake - r_in.now_ms;
    assign take_best = i_cmd.scan_eval && (!r_have_best || (remaining < r_best_wait));

    assign wr_en   = i_cmd.push || i_cmd.wr_shift;
    assign wr_addr = i_cmd.push ? AW'(r_count) : i_wr_addr;
    assign wr_task  = i_cmd.push ? TASK_ID_BITS'(r_in.task_id) : r_rd_task;
    assign wr_sleep = i_cmd.push ? r_in.sleep_request : r_rd_sleep;
    assign wr_wake  = i_cmd.push ? push_wake : r_rd_wake;

    always_comb begin
        n_res_status = r_res_status;
        n_res_task   = r_res_task;
        n_res_wait   = r_res_wait;
        if (i_cmd.load_ready) begin
            n_res_status = ST_READY;
            n_res_task   = r_rd_task;
            n_res_wait   = '0;
        end else if (i_cmd.load_best) begin
            n_res_status = ST_WAITED;
            n_res_task   = r_best_task;
            n_res_wait   = r_best_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_task[wr_addr]  <= wr_task;
            r_mem_sleep[wr_addr] <= wr_sleep;
            r_mem_wake[wr_addr]  <= wr_wake;
        end
        if (i_cmd.rd_en) begin
            r_rd_task   <= r_mem_task[i_rd_addr];
            r_rd_sleep  <= r_mem_sleep[i_rd_addr];
            r_rd_wake   <= r_mem_wake[i_rd_addr];
            r_rd_addr_q <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_req;
        end
        if (take_best) begin
            r_best_wait <= remaining;
            r_best_pos  <= r_rd_addr_q;
            r_best_task <= r_rd_task;
        end
        r_res_status <= n_res_status;
        r_res_task   <= n_res_task;
        r_res_wait   <= n_res_wait;
        if (i_cmd.emit) begin
            r_out.status      <= i_cmd.emit_status;
            r_out.chosen_task <= '0;
            r_out.wait_ms     <= '0;
        end else if (i_cmd.emit_held) begin
            r_out.status      <= n_res_status;
            r_out.chosen_task <= TASK_FIELD_BITS'(n_res_task);
            r_out.wait_ms     <= n_res_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_main_alive <= 1'b1;
            r_have_best  <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit || i_cmd.emit_held;
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.kill_main) begin
                r_main_alive <= 1'b0;
            end
            if (i_cmd.scan_clear) begin
                r_have_best <= 1'b0;
            end else if (take_best) begin
                r_have_best <= 1'b1;
            end
        end
    end

    assign o_stat.req_type   = r_in.req_type;
    assign o_stat.full       = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.main_alive = r_main_alive;
    assign o_stat.ready_hit  = ready_hit;
    assign o_count           = r_count;
    assign o_best_pos        = r_best_pos;
    assign o_result          = r_out;
    assign o_strobe          = r_strobe;

endmodule

[hdl/rqts_ctrl.sv]
// Controller of the ready queue: sequences push, pick scan, compaction and kill.
// Drives the datapath through command structs. Depends on rqts_pkg.
`timescale 1ns / 1ps

module rqts_ctrl
    import rqts_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  t_dp_stat                         i_stat,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_count,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]   i_best_pos,
    output t_dp_cmd                          o_cmd,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   o_rd_addr,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   o_wr_addr
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_BEST,
        S_SHIFT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_last, n_last;
    logic          r_busy, n_busy;

    logic          start_remove;
    logic [CW-1:0] remove_pos;
    logic [CW-1:0] remove_next;
    logic [CW-1:0] last_next;

    assign last_next = r_last + CW'(1);

    always_comb begin
        o_cmd        = '0;
        o_cmd.emit_status = ST_NONE;
        o_rd_addr    = '0;
        o_wr_addr    = '0;
        n_state      = r_state;
        n_idx        = r_idx;
        n_last       = r_last;
        n_busy       = r_busy;
        start_remove = 1'b0;
        remove_pos   = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch_in = 1'b1;
                    n_busy         = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state    = S_IDLE;
                n_busy     = 1'b0;
                o_cmd.emit = 1'b1;
                unique case (i_stat.req_type)
                    REQ_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.emit_status = ST_DROPPED;
                        end else begin
                            o_cmd.push        = 1'b1;
                            o_cmd.emit_status = ST_PUSHED;
                        end
                    end
                    REQ_PICK: begin
                        if (i_stat.empty) begin
                            o_cmd.emit_status = i_stat.main_alive ? ST_MAIN : ST_NONE;
                        end else begin
                            o_cmd.emit       = 1'b0;
                            o_cmd.scan_clear = 1'b1;
                            o_cmd.rd_en      = 1'b1;
                            o_rd_addr        = '0;
                            n_last           = '0;
                            n_idx            = CW'(1);
                            n_busy           = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    REQ_KILL: begin
                        o_cmd.kill_main   = 1'b1;
                        o_cmd.emit_status = ST_KILLED;
                    end
                    default: begin
                        o_cmd.emit_status = ST_NONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.ready_hit) begin
                    o_cmd.load_ready = 1'b1;
                    start_remove     = 1'b1;
                    remove_pos       = r_last;
                end else begin
                    o_cmd.scan_eval = 1'b1;
                    if (r_idx < i_count) begin
                        o_cmd.rd_en = 1'b1;
                        o_rd_addr   = AW'(r_idx);
                        n_last      = r_idx;
                        n_idx       = r_idx + CW'(1);
                    end else begin
                        n_state = S_BEST;
                    end
                end
            end
            S_BEST: begin
                o_cmd.load_best = 1'b1;
                start_remove    = 1'b1;
                remove_pos      = CW'(i_best_pos);
            end
            S_SHIFT: begin
                o_cmd.wr_shift = 1'b1;
                o_wr_addr      = AW'(r_last - CW'(1));
                if (last_next < i_count) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = AW'(last_next);
                    n_last      = last_next;
                end else begin
                    o_cmd.emit_held = 1'b1;
                    o_cmd.dec_count = 1'b1;
                    n_busy          = 1'b0;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase

        // Removal closes the gap by moving each later entry down by one.
        remove_next = remove_pos + CW'(1);
        if (start_remove) begin
            if (remove_next < i_count) begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = AW'(remove_next);
                n_last      = remove_next;
                n_state     = S_SHIFT;
            end else begin
                o_cmd.emit_held = 1'b1;
                o_cmd.dec_count = 1'b1;
                n_busy          = 1'b0;
                n_state         = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_last  <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_last  <= n_last;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

[hdl/ready_queue_with_timed_sleep_top.sv]
// Ready queue with timed sleep: top level joining the controller and the datapath.
// Push, kill, an unused code and a pick on an empty queue answer straight from dispatch. A pick
// otherwise scans entries one per cycle, passes through a best-sleeper state when a sleeper
// is chosen, and moves later entries down one per cycle to close the gap.
// One request at a time: busy drops in the strobe cycle, so the next transfer may come then.
// Synchronous active-low reset empties the queue, revives main.
`timescale 1ns / 1ps

module ready_queue_with_timed_sleep_top
    import rqts_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_req_item i_req,
    output t_result   o_result,
    output logic      o_strobe
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // The controller sequences each request; the datapath owns the entry memory,
    // the count, the main-task flag and the result register. A transfer takes
    // place when start is high while busy is low. Every request yields exactly
    // one result, shown for one cycle with o_strobe high; the receiver cannot
    // stall it, and the next request may be transferred in that same cycle.

    t_dp_cmd       dp_cmd;
    t_dp_stat      dp_stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] count;
    logic [AW-1:0] best_pos;

    // A pick reads entries from the head, one per cycle. The first awake or
    // expired entry is taken at once; otherwise the scan runs to the tail while
    // the datapath keeps the sleeper with the least remaining time, the one
    // nearest the head winning a tie. The chosen entry is then removed by
    // copying each later entry one place toward the head.
    rqts_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_stat     (dp_stat),
        .i_count    (count),
        .i_best_pos (best_pos),
        .o_cmd      (dp_cmd),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr)
    );

    // Entry storage is a plain memory with one write and one registered read
    // port; entries at or beyond the count are never read, so it needs no clear.
    rqts_dpath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd      (dp_cmd),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .o_stat     (dp_stat),
        .o_count    (count),
        .o_best_pos (best_pos),
        .o_result   (o_result),
        .o_strobe   (o_strobe)
    );

endmodule
